// File: hw/rtl/ttig_pkg.sv
// Shared types and constants for the terrain tile index generator.
// No dependencies; imported by ttig_core and terrain_tile_index_generator.
package ttig_pkg;

  localparam int IDX_W = 16;

  // Register index taken from paddr[2]
  localparam logic REG_DETAIL_LEVEL = 1'b0;

  localparam logic [3:0] DETAIL_RESET = 4'd6;

  typedef enum logic [2:0] {
    SEC_GRID,
    SEC_LEFT,
    SEC_RIGHT,
    SEC_TOP,
    SEC_BOTTOM
  } sect_e;

  typedef enum logic [1:0] {
    PH_OPEN,
    PH_RUN,
    PH_CLOSE
  } phase_e;

  // Walk state that does not depend on the tile size
  typedef struct packed {
    sect_e              sec;
    phase_e             ph;
    logic               done;
    logic [3:0]         lod;
    logic [IDX_W-1:0]   acc_lv;   // row * vertices per grid row
    logic [IDX_W-1:0]   acc_inc;  // segment * step
  } ctrl_t;

  typedef struct packed {
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] c;
    logic             last;
  } tri_t;

endpackage

// File: hw/rtl/ttig_core.sv
// Next-state and triangle logic of the tile walk (combinational).
// Depends on ttig_pkg; instantiated by terrain_tile_index_generator.
module ttig_core import ttig_pkg::*; #(
  parameter int TILE_SIZE = 242,
  parameter int CW        = $clog2(TILE_SIZE - 1)
) (
  input  logic          restart_i,
  input  logic [3:0]    detail_level_i,
  input  ctrl_t         ctl_i,
  input  logic [CW-1:0] row_i,
  input  logic [CW-1:0] col_i,
  output ctrl_t         ctl_o,
  output logic [CW-1:0] row_o,
  output logic [CW-1:0] col_o,
  output tri_t          tri_o
);

  localparam int SEG0 = (TILE_SIZE - 2) / 12;
  localparam int SEG1 = (TILE_SIZE - 2) / 10;
  localparam int SEG2 = (TILE_SIZE - 2) / 8;
  localparam int SEG3 = (TILE_SIZE - 2) / 6;
  localparam int SEG4 = (TILE_SIZE - 2) / 4;
  localparam int SEG5 = (TILE_SIZE - 2) / 2;
  localparam int SEG6 = TILE_SIZE - 2;

  localparam logic [IDX_W-1:0] BV     = IDX_W'(TILE_SIZE + 1);
  localparam logic [IDX_W-1:0] BV_X2  = IDX_W'(2 * (TILE_SIZE + 1));
  localparam logic [IDX_W-1:0] BV_X3  = IDX_W'(3 * (TILE_SIZE + 1));
  localparam logic [IDX_W-1:0] TS     = IDX_W'(TILE_SIZE);

  function automatic logic [3:0] inc_of(input logic [3:0] lod);
    case (lod)
      4'd0:    return 4'd12;
      4'd1:    return 4'd10;
      4'd2:    return 4'd8;
      4'd3:    return 4'd6;
      4'd4:    return 4'd4;
      4'd5:    return 4'd2;
      default: return 4'd1;
    endcase
  endfunction

  function automatic logic [CW-1:0] seg_of(input logic [3:0] lod);
    case (lod)
      4'd0:    return CW'(SEG0);
      4'd1:    return CW'(SEG1);
      4'd2:    return CW'(SEG2);
      4'd3:    return CW'(SEG3);
      4'd4:    return CW'(SEG4);
      4'd5:    return CW'(SEG5);
      default: return CW'(SEG6);
    endcase
  endfunction

  // (seg+1)^2, truncated to the index width
  function automatic logic [IDX_W-1:0] lvsq_of(input logic [3:0] lod);
    case (lod)
      4'd0:    return IDX_W'((SEG0 + 1) * (SEG0 + 1));
      4'd1:    return IDX_W'((SEG1 + 1) * (SEG1 + 1));
      4'd2:    return IDX_W'((SEG2 + 1) * (SEG2 + 1));
      4'd3:    return IDX_W'((SEG3 + 1) * (SEG3 + 1));
      4'd4:    return IDX_W'((SEG4 + 1) * (SEG4 + 1));
      4'd5:    return IDX_W'((SEG5 + 1) * (SEG5 + 1));
      default: return IDX_W'((SEG6 + 1) * (SEG6 + 1));
    endcase
  endfunction

  // seg*(seg+1): first vertex of the last grid row
  function automatic logic [IDX_W-1:0] seglv_of(input logic [3:0] lod);
    case (lod)
      4'd0:    return IDX_W'(SEG0 * (SEG0 + 1));
      4'd1:    return IDX_W'(SEG1 * (SEG1 + 1));
      4'd2:    return IDX_W'(SEG2 * (SEG2 + 1));
      4'd3:    return IDX_W'(SEG3 * (SEG3 + 1));
      4'd4:    return IDX_W'(SEG4 * (SEG4 + 1));
      4'd5:    return IDX_W'(SEG5 * (SEG5 + 1));
      default: return IDX_W'(SEG6 * (SEG6 + 1));
    endcase
  endfunction

  logic             start;
  ctrl_t            eff;
  logic [CW-1:0]    e_row;
  logic [CW-1:0]    e_col;
  logic [3:0]       inc;
  logic [CW-1:0]    seg;
  logic [IDX_W-1:0] seg16;
  logic [IDX_W-1:0] lv;
  logic [IDX_W-1:0] lvsq;
  logic [IDX_W-1:0] seglv;
  logic [IDX_W-1:0] base;
  logic [CW:0]      row_inc;
  logic [CW:0]      col_inc;
  logic             row_wrap;
  logic [IDX_W-1:0] ga;
  logic [IDX_W-1:0] gb;
  logic [IDX_W-1:0] gc;
  logic [IDX_W-1:0] gd;
  logic [IDX_W-1:0] bi;
  logic [IDX_W-1:0] bim;
  logic [IDX_W-1:0] li;
  logic [IDX_W-1:0] bv_m1;
  logic [IDX_W-1:0] bv_m2;
  logic             sub0;

  always_comb begin
    start = restart_i | ctl_i.done;
    if (start) begin
      eff = '{sec: SEC_GRID, ph: PH_OPEN, done: 1'b0, lod: detail_level_i,
              acc_lv: '0, acc_inc: '0};
      e_row = '0;
      e_col = '0;
    end else begin
      eff   = ctl_i;
      e_row = row_i;
      e_col = col_i;
    end
  end

  always_comb begin
    inc     = inc_of(eff.lod);
    seg     = seg_of(eff.lod);
    lvsq    = lvsq_of(eff.lod);
    seglv   = seglv_of(eff.lod);
    seg16   = IDX_W'(seg);
    lv      = seg16 + 1'b1;
    row_inc = {1'b0, e_row} + 1'b1;
    col_inc = {1'b0, e_col} + 1'b1;
    row_wrap = row_inc >= {1'b0, seg};
    case (eff.sec)
      SEC_LEFT:  base = lvsq;
      SEC_RIGHT: base = lvsq + BV;
      SEC_TOP:   base = lvsq + BV_X2;
      default:   base = lvsq + BV_X3;
    endcase
    ga    = IDX_W'(e_col) + eff.acc_lv;
    gb    = ga + lv;
    gc    = gb + 1'b1;
    gd    = ga + 1'b1;
    bi    = base + 1'b1 + eff.acc_inc;
    bim   = bi + IDX_W'(e_col) - 1'b1;
    sub0  = e_col == '0;
    bv_m1 = base + BV - 1'b1;
    bv_m2 = base + BV - 2'd2;
    case (eff.sec)
      SEC_LEFT:  li = eff.acc_lv;
      SEC_RIGHT: li = seg16 + eff.acc_lv;
      SEC_TOP:   li = IDX_W'(e_row);
      default:   li = seglv + IDX_W'(e_row);
    endcase
  end

  always_comb begin
    ctl_o      = eff;
    ctl_o.done = 1'b0;
    row_o      = e_row;
    col_o      = e_col;
    tri_o      = '0;
    if (eff.sec == SEC_GRID) begin
      if (eff.ph == PH_OPEN) begin
        ctl_o.ph = PH_RUN;
        tri_o    = '{a: ga, b: gb, c: gd, last: 1'b0};
      end else begin
        ctl_o.ph = PH_OPEN;
        tri_o    = '{a: gb, b: gc, c: gd, last: 1'b0};
        if (col_inc >= {1'b0, seg}) begin
          col_o = '0;
          if (row_wrap) begin
            row_o        = '0;
            ctl_o.acc_lv = '0;
            ctl_o.sec    = SEC_LEFT;
          end else begin
            row_o        = row_inc[CW-1:0];
            ctl_o.acc_lv = eff.acc_lv + lv;
          end
        end else begin
          col_o = col_inc[CW-1:0];
        end
      end
    end else begin
      case (eff.ph)
        PH_OPEN: begin
          ctl_o.ph      = PH_RUN;
          ctl_o.acc_lv  = '0;
          ctl_o.acc_inc = '0;
          row_o         = '0;
          col_o         = '0;
          case (eff.sec)
            SEC_LEFT:  tri_o = '{a: base, b: base + 1'b1, c: '0, last: 1'b0};
            SEC_RIGHT: tri_o = '{a: base, b: seg16, c: base + 1'b1, last: 1'b0};
            SEC_TOP:   tri_o = '{a: base, b: '0, c: base + 1'b1, last: 1'b0};
            default:   tri_o = '{a: base, b: base + 1'b1, c: seglv, last: 1'b0};
          endcase
        end
        PH_RUN: begin
          if (col_inc > (CW + 1)'(inc)) begin
            col_o = '0;
            if (row_wrap) begin
              row_o         = '0;
              ctl_o.acc_lv  = '0;
              ctl_o.acc_inc = '0;
              ctl_o.ph      = PH_CLOSE;
            end else begin
              row_o         = row_inc[CW-1:0];
              ctl_o.acc_lv  = eff.acc_lv + lv;
              ctl_o.acc_inc = eff.acc_inc + IDX_W'(inc);
            end
          end else begin
            col_o = col_inc[CW-1:0];
          end
          case (eff.sec)
            SEC_LEFT:
              tri_o = sub0 ? tri_t'{a: li, b: bi, c: li + lv, last: 1'b0}
                           : tri_t'{a: bim, b: bim + 1'b1, c: li + lv, last: 1'b0};
            SEC_RIGHT:
              tri_o = sub0 ? tri_t'{a: li, b: li + lv, c: bi, last: 1'b0}
                           : tri_t'{a: bim, b: li + lv, c: bim + 1'b1, last: 1'b0};
            SEC_TOP:
              tri_o = sub0 ? tri_t'{a: li, b: li + 1'b1, c: bi, last: 1'b0}
                           : tri_t'{a: bim, b: li + 1'b1, c: bim + 1'b1, last: 1'b0};
            default:
              tri_o = sub0 ? tri_t'{a: li, b: bi, c: li + 1'b1, last: 1'b0}
                           : tri_t'{a: bim, b: bim + 1'b1, c: li + 1'b1, last: 1'b0};
          endcase
        end
        default: begin
          ctl_o.ph      = PH_OPEN;
          ctl_o.acc_lv  = '0;
          ctl_o.acc_inc = '0;
          row_o         = '0;
          col_o         = '0;
          case (eff.sec)
            SEC_LEFT: begin
              ctl_o.sec = SEC_RIGHT;
              tri_o     = '{a: bv_m2, b: bv_m1, c: seglv, last: 1'b0};
            end
            SEC_RIGHT: begin
              ctl_o.sec = SEC_TOP;
              tri_o     = '{a: base + TS, b: base + TS - 1'b1, c: lvsq - 1'b1,
                            last: 1'b0};
            end
            SEC_TOP: begin
              ctl_o.sec = SEC_BOTTOM;
              tri_o     = '{a: bv_m2, b: seg16, c: bv_m1, last: 1'b0};
            end
            default: begin
              ctl_o.sec  = SEC_GRID;
              ctl_o.done = 1'b1;
              tri_o      = '{a: lvsq - 1'b1, b: bv_m2, c: bv_m1, last: 1'b1};
            end
          endcase
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/terrain_tile_index_generator.sv
// Top level of the terrain tile index generator: handshake, state, APB register.
// Depends on ttig_pkg and ttig_core.
//
//   channel  | direction | handshake                  | payload
//   ---------+-----------+----------------------------+---------------------------------
//   request  | in        | req_valid_i / req_ready_o  | restart_i
//   triangle | out       | tri_valid_o / tri_ready_i  | corner_a/b/c_o, last_of_tile_o
//   config   | in        | APB psel/penable/pready    | detail_level at paddr 0
//
// One request per cycle; each request's triangle is registered and shown in the cycle after.
// The triangle register is the only stage; a new request is taken while the
// held triangle is read in the same cycle. A stalled triangle holds requests.
// After reset detail_level is 6 and the first request starts a fresh tile.
module terrain_tile_index_generator import ttig_pkg::*; #(
  parameter int TILE_SIZE = 242
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  logic        restart_i,
  output logic        tri_valid_o,
  input  logic        tri_ready_i,
  output logic [15:0] corner_a_o,
  output logic [15:0] corner_b_o,
  output logic [15:0] corner_c_o,
  output logic        last_of_tile_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW = $clog2(TILE_SIZE - 1);

  logic          req_fire;
  logic [3:0]    detail_level_q;
  ctrl_t         ctl_q;
  ctrl_t         ctl_d;
  logic [CW-1:0] row_q;
  logic [CW-1:0] row_d;
  logic [CW-1:0] col_q;
  logic [CW-1:0] col_d;
  tri_t          tri_q;
  tri_t          tri_d;
  logic          tri_valid_q;

  ttig_core #(
    .TILE_SIZE (TILE_SIZE),
    .CW        (CW)
  ) u_core (
    .restart_i      (restart_i),
    .detail_level_i (detail_level_q),
    .ctl_i          (ctl_q),
    .row_i          (row_q),
    .col_i          (col_q),
    .ctl_o          (ctl_d),
    .row_o          (row_d),
    .col_o          (col_d),
    .tri_o          (tri_d)
  );

  assign req_ready_o = ~tri_valid_q | tri_ready_i;
  assign req_fire    = req_valid_i & req_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q       <= '{sec: SEC_GRID, ph: PH_OPEN, done: 1'b1, lod: DETAIL_RESET,
                       acc_lv: '0, acc_inc: '0};
      row_q       <= '0;
      col_q       <= '0;
      tri_valid_q <= 1'b0;
    end else begin
      if (req_fire) begin
        ctl_q       <= ctl_d;
        row_q       <= row_d;
        col_q       <= col_d;
        tri_valid_q <= 1'b1;
      end else if (tri_ready_i) begin
        tri_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      tri_q <= tri_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      detail_level_q <= DETAIL_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_DETAIL_LEVEL) begin
      detail_level_q <= pwdata[3:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DETAIL_LEVEL) ? {28'b0, detail_level_q} : 32'b0;

  assign tri_valid_o    = tri_valid_q;
  assign corner_a_o     = tri_q.a;
  assign corner_b_o     = tri_q.b;
  assign corner_c_o     = tri_q.c;
  assign last_of_tile_o = tri_q.last;

`ifndef SYNTHESIS
  a_last_ends_tile: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire && tri_d.last |=> ctl_q.done)
    else $error("tile not closed after its last triangle");

  a_done_rewound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_q.done |-> ctl_q.sec == SEC_GRID && ctl_q.ph == PH_OPEN)
    else $error("finished tile left walk state behind");

  a_grid_no_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_q.sec == SEC_GRID |-> ctl_q.ph != PH_CLOSE)
    else $error("closing phase inside the interior grid");
`endif

endmodule
